/* hw/rtl/ntpm_pkg.sv */
// Package for the nearest timestamp pair matcher.
// Holds the operation and result codes and the fixed field widths.
// No dependencies.
package ntpm_pkg;

    localparam int STAMP_BITS    = 63;
    localparam int MAX_RESULTS   = 16;
    localparam int RES_CNT_BITS  = $clog2(MAX_RESULTS + 1);

    typedef logic [1:0] t_op;

    localparam t_op OP_PUSH_POSE  = 2'd0;
    localparam t_op OP_PUSH_IMAGE = 2'd1;
    localparam t_op OP_FLUSH      = 2'd2;

    localparam logic KIND_MATCH = 1'b0;
    localparam logic KIND_DROP  = 1'b1;

endpackage

/* hw/rtl/ntpm_if.sv */
// Request and result channel interfaces of the nearest timestamp pair matcher.
// Depends on ntpm_pkg for the operation type and the stamp width.
interface ntpm_req_if import ntpm_pkg::*; #(
    parameter int TAG_BITS = 16
);
    logic                  valid;
    logic                  ready;
    t_op                   operation;
    logic [STAMP_BITS-1:0] stamp;
    logic [TAG_BITS-1:0]   item_tag;

    modport source (output valid, operation, stamp, item_tag, input ready);
    modport sink   (input valid, operation, stamp, item_tag, output ready);
endinterface

interface ntpm_res_if import ntpm_pkg::*; #(
    parameter int TAG_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic                  kind;
    logic [STAMP_BITS-1:0] pose_stamp;
    logic [STAMP_BITS-1:0] image_stamp;
    logic [TAG_BITS-1:0]   pose_tag;
    logic [TAG_BITS-1:0]   image_tag;
    logic                  last;

    modport source (output valid, kind, pose_stamp, image_stamp, pose_tag, image_tag, last,
                    input ready);
    modport sink   (input valid, kind, pose_stamp, image_stamp, pose_tag, image_tag, last,
                    output ready);
endinterface

/* hw/rtl/ntpm_ram.sv */
// Generic single write port, single read port RAM with a registered read.
// No dependencies.
module ntpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/nearest_timestamp_pair_matcher.sv */
// Top level of the nearest timestamp pair matcher.
// Depends on ntpm_pkg, the channel interfaces in ntpm_if and ntpm_ram.
//
// Requests arrive on i_req: push a pose item, push an image item, or flush.
// Results leave on o_res: matched pairs, or a drop report when a push meets
// a full queue; last marks the final result of a request.
// Each queue lives in one RAM holding stamp and tag, with a registered read.
// A request is taken only when the matcher is idle. A push writes its queue
// in the accept cycle. Every matching step then runs S_RD1, S_RD2, S_CMP
// and S_DEC: two RAM reads (both heads, then both successors), a distance
// stage and a decision, which waits while a held result cannot go out.
// A pop returns to the head reads; a walk that stops goes to S_DONE to
// release the held result. A request runs one step per pop or match that
// it causes (up to 16 matches per request).
// The newest match is held back one step so that last can be set on it.
// When the receiver stalls, the matcher waits at the next result it has to
// deliver and keeps all its state. Reset empties both queues and the result
// registers; the RAM contents are not cleared.
module nearest_timestamp_pair_matcher import ntpm_pkg::*; #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ntpm_req_if.sink   i_req,
    ntpm_res_if.source o_res
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int MW = STAMP_BITS + TAG_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_CMP,
        S_DEC,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                  kind;
        logic [STAMP_BITS-1:0] pose_stamp;
        logic [STAMP_BITS-1:0] image_stamp;
        logic [TAG_BITS-1:0]   pose_tag;
        logic [TAG_BITS-1:0]   image_tag;
    } t_res;

    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] head,
                                             input logic [CW-1:0] k);
        logic [CW:0] s;
        s = (CW+1)'(head) + (CW+1)'(k);
        if (s >= (CW+1)'(QUEUE_DEPTH)) begin
            s = s - (CW+1)'(QUEUE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    t_state                r_state, n_state;
    logic                  r_flush, n_flush;
    logic [AW-1:0]         r_ph, n_ph, r_ih, n_ih;
    logic [CW-1:0]         r_pc, n_pc, r_ic, n_ic;
    logic [RES_CNT_BITS-1:0] r_nres, n_nres;
    logic [STAMP_BITS-1:0] r_p1, n_p1, r_i1, n_i1;
    logic [TAG_BITS-1:0]   r_pt1, n_pt1, r_it1, n_it1;
    logic [STAMP_BITS-1:0] r_d1, n_d1, r_d2, n_d2;
    logic                  r_pose_older, n_pose_older;
    t_res                  r_hold, n_hold;
    logic                  r_hold_valid, n_hold_valid;
    t_res                  r_out, n_out;
    logic                  r_out_last, n_out_last;
    logic                  r_out_valid, n_out_valid;

    logic                  req_fire, out_free;
    logic                  p_we, i_we;
    logic [AW-1:0]         p_waddr, i_waddr, p_raddr, i_raddr;
    logic [MW-1:0]         wdata, p_rdata, i_rdata;
    logic [STAMP_BITS-1:0] p_rd_stamp, i_rd_stamp;
    logic [STAMP_BITS-1:0] dp2, di2;
    logic                  older_c, pop_ok, older_gt1;

    ntpm_ram #(.WIDTH(MW), .DEPTH(QUEUE_DEPTH)) u_pose_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    ntpm_ram #(.WIDTH(MW), .DEPTH(QUEUE_DEPTH)) u_image_ram (
        .i_clk   (i_clk),
        .i_we    (i_we),
        .i_waddr (i_waddr),
        .i_wdata (wdata),
        .i_raddr (i_raddr),
        .o_rdata (i_rdata)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_res.ready;

    assign wdata   = {i_req.stamp, i_req.item_tag};
    assign p_waddr = f_slot(r_ph, r_pc);
    assign i_waddr = f_slot(r_ih, r_ic);
    assign p_we    = req_fire && (i_req.operation == OP_PUSH_POSE)
                     && (r_pc != CW'(QUEUE_DEPTH));
    assign i_we    = req_fire && (i_req.operation == OP_PUSH_IMAGE)
                     && (r_ic != CW'(QUEUE_DEPTH));

    assign p_raddr = (r_state == S_RD2) ? f_slot(r_ph, CW'(1)) : r_ph;
    assign i_raddr = (r_state == S_RD2) ? f_slot(r_ih, CW'(1)) : r_ih;

    assign p_rd_stamp = p_rdata[MW-1:TAG_BITS];
    assign i_rd_stamp = i_rdata[MW-1:TAG_BITS];

    assign older_c = r_p1 < r_i1;
    assign dp2 = (p_rd_stamp > r_i1) ? p_rd_stamp - r_i1 : r_i1 - p_rd_stamp;
    assign di2 = (i_rd_stamp > r_p1) ? i_rd_stamp - r_p1 : r_p1 - i_rd_stamp;

    assign older_gt1 = r_pose_older ? (r_pc > CW'(1)) : (r_ic > CW'(1));
    assign pop_ok    = older_gt1 && (r_d2 <= r_d1);

    always_comb begin
        n_state      = r_state;
        n_flush      = r_flush;
        n_ph         = r_ph;
        n_ih         = r_ih;
        n_pc         = r_pc;
        n_ic         = r_ic;
        n_nres       = r_nres;
        n_p1         = r_p1;
        n_i1         = r_i1;
        n_pt1        = r_pt1;
        n_it1        = r_it1;
        n_d1         = r_d1;
        n_d2         = r_d2;
        n_pose_older = r_pose_older;
        n_hold       = r_hold;
        n_hold_valid = r_hold_valid;
        n_out        = r_out;
        n_out_last   = r_out_last;
        n_out_valid  = r_out_valid && !o_res.ready;

        case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_nres  = '0;
                    n_flush = (i_req.operation == OP_FLUSH);
                    case (i_req.operation)
                        OP_PUSH_POSE, OP_PUSH_IMAGE: begin
                            if ((i_req.operation == OP_PUSH_POSE && r_pc == CW'(QUEUE_DEPTH))
                                || (i_req.operation == OP_PUSH_IMAGE
                                    && r_ic == CW'(QUEUE_DEPTH))) begin
                                n_hold.kind        = KIND_DROP;
                                n_hold.pose_stamp  = i_req.stamp;
                                n_hold.image_stamp = '0;
                                n_hold.pose_tag    = i_req.item_tag;
                                n_hold.image_tag   = '0;
                                n_hold_valid       = 1'b1;
                                n_state            = S_DONE;
                            end else begin
                                if (i_req.operation == OP_PUSH_POSE) begin
                                    n_pc = r_pc + CW'(1);
                                end else begin
                                    n_ic = r_ic + CW'(1);
                                end
                                n_state = S_RD1;
                            end
                        end
                        OP_FLUSH: begin
                            n_state = S_RD1;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD1: begin
                if (r_pc != '0 && r_ic != '0 && r_nres < RES_CNT_BITS'(MAX_RESULTS)
                    && (r_flush || (r_pc > CW'(1) && r_ic > CW'(1)))) begin
                    n_state = S_RD2;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RD2: begin
                n_p1    = p_rd_stamp;
                n_pt1   = p_rdata[TAG_BITS-1:0];
                n_i1    = i_rd_stamp;
                n_it1   = i_rdata[TAG_BITS-1:0];
                n_state = S_CMP;
            end
            S_CMP: begin
                n_pose_older = older_c;
                n_d1         = older_c ? r_i1 - r_p1 : r_p1 - r_i1;
                n_d2         = older_c ? dp2 : di2;
                n_state      = S_DEC;
            end
            S_DEC: begin
                if (pop_ok) begin
                    if (r_pose_older) begin
                        n_ph = f_slot(r_ph, CW'(1));
                        n_pc = r_pc - CW'(1);
                    end else begin
                        n_ih = f_slot(r_ih, CW'(1));
                        n_ic = r_ic - CW'(1);
                    end
                    n_state = S_RD1;
                end else if (!older_gt1 && !r_flush) begin
                    n_state = S_DONE;
                end else if (!r_hold_valid || out_free) begin
                    if (r_hold_valid) begin
                        n_out       = r_hold;
                        n_out_last  = 1'b0;
                        n_out_valid = 1'b1;
                    end
                    n_hold.kind        = KIND_MATCH;
                    n_hold.pose_stamp  = r_p1;
                    n_hold.image_stamp = r_i1;
                    n_hold.pose_tag    = r_pt1;
                    n_hold.image_tag   = r_it1;
                    n_hold_valid       = 1'b1;
                    n_ph               = f_slot(r_ph, CW'(1));
                    n_pc               = r_pc - CW'(1);
                    n_ih               = f_slot(r_ih, CW'(1));
                    n_ic               = r_ic - CW'(1);
                    n_nres             = r_nres + RES_CNT_BITS'(1);
                    n_state            = S_RD1;
                end
            end
            S_DONE: begin
                if (!r_hold_valid) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out        = r_hold;
                    n_out_last   = 1'b1;
                    n_out_valid  = 1'b1;
                    n_hold_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_p1         <= n_p1;
        r_i1         <= n_i1;
        r_pt1        <= n_pt1;
        r_it1        <= n_it1;
        r_d1         <= n_d1;
        r_d2         <= n_d2;
        r_pose_older <= n_pose_older;
        r_hold       <= n_hold;
        r_out        <= n_out;
        r_out_last   <= n_out_last;
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_flush      <= 1'b0;
            r_ph         <= '0;
            r_ih         <= '0;
            r_pc         <= '0;
            r_ic         <= '0;
            r_nres       <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_flush      <= n_flush;
            r_ph         <= n_ph;
            r_ih         <= n_ih;
            r_pc         <= n_pc;
            r_ic         <= n_ic;
            r_nres       <= n_nres;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.kind        = r_out.kind;
    assign o_res.pose_stamp  = r_out.pose_stamp;
    assign o_res.image_stamp = r_out.image_stamp;
    assign o_res.pose_tag    = r_out.pose_tag;
    assign o_res.image_tag   = r_out.image_tag;
    assign o_res.last        = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= CW'(QUEUE_DEPTH) && r_ic <= CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_push_pose: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        p_we |=> r_pc == $past(r_pc) + CW'(1))
        else $error("accepted pose push did not grow the queue");

    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !r_hold_valid)
        else $error("held result left behind at idle");

    a_res_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nres <= RES_CNT_BITS'(MAX_RESULTS))
        else $error("too many matches for one request");

endmodule

/* test/tb.sv */
// Self-checking testbench for nearest_timestamp_pair_matcher.
// Drives pose, image and flush requests with random idling on both channels and checks
// every result against an in-bench pairing predictor. Depends on ntpm_pkg, ntpm_if and the DUT.
module tb;
    import ntpm_pkg::*;

    localparam int QDEPTH    = 16;
    localparam int QAW       = $clog2(QDEPTH);
    localparam int TAGW      = 16;
    localparam int LIMIT     = 400000;
    localparam int DRAIN     = 200;
    localparam int EXP_DEPTH = 64;
    localparam int EXP_AW    = $clog2(EXP_DEPTH);
    localparam t_op OP_UNUSED = 2'd3;
    localparam logic [STAMP_BITS-1:0] STAMP_MAX = {STAMP_BITS{1'b1}};

    typedef struct packed {
        logic                  kind;
        logic [STAMP_BITS-1:0] pose_stamp;
        logic [STAMP_BITS-1:0] image_stamp;
        logic [TAGW-1:0]       pose_tag;
        logic [TAGW-1:0]       image_tag;
        logic                  last;
    } pair_result_t;

    logic i_clk;
    logic i_rst_n;

    ntpm_req_if #(.TAG_BITS(TAGW)) req_ch ();
    ntpm_res_if #(.TAG_BITS(TAGW)) res_ch ();

    nearest_timestamp_pair_matcher #(
        .QUEUE_DEPTH (QDEPTH),
        .TAG_BITS    (TAGW)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    pair_result_t          exp_mem [EXP_DEPTH];
    int unsigned           exp_wr, exp_rd;
    logic [STAMP_BITS-1:0] pose_stamp_q  [QDEPTH];
    logic [TAGW-1:0]       pose_tag_q    [QDEPTH];
    logic [STAMP_BITS-1:0] image_stamp_q [QDEPTH];
    logic [TAGW-1:0]       image_tag_q   [QDEPTH];
    logic [QAW-1:0]        pose_rd, image_rd;
    int unsigned           pose_cnt, image_cnt;

    int                    mismatches;
    int                    cycles;
    int                    stall_left;
    bit                    quiet_tail;
    logic [STAMP_BITS-1:0] sensor_clock;
    logic [STAMP_BITS-1:0] last_stamp;

    pair_result_t          got_pair;
    pair_result_t          want_pair;

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    function automatic logic [STAMP_BITS-1:0] wide_random();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[STAMP_BITS-1:0];
    endfunction

    function automatic logic [TAGW-1:0] tag_random();
        return TAGW'($urandom_range(0, 65535));
    endfunction

    function automatic logic [QAW-1:0] qslot(logic [QAW-1:0] base, int unsigned k);
        return QAW'((32'(base) + k) % QDEPTH);
    endfunction

    function automatic logic [STAMP_BITS-1:0] stamp_gap(logic [STAMP_BITS-1:0] a,
                                                          logic [STAMP_BITS-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic void queue_result(logic kind, logic [STAMP_BITS-1:0] ps,
                                         logic [STAMP_BITS-1:0] is, logic [TAGW-1:0] pt,
                                         logic [TAGW-1:0] it, logic lst);
        pair_result_t r;
        r.kind        = kind;
        r.pose_stamp  = ps;
        r.image_stamp = is;
        r.pose_tag    = pt;
        r.image_tag   = it;
        r.last        = lst;
        exp_mem[EXP_AW'(exp_wr)] = r;
        exp_wr++;
    endfunction

    function automatic int match_heads(bit flushing);
        int                    n;
        logic [STAMP_BITS-1:0] p1, i1, nxt;
        n = 0;
        while (pose_cnt > 0 && image_cnt > 0 && n < MAX_RESULTS) begin
            if (!flushing && (pose_cnt < 2 || image_cnt < 2))
                break;
            p1 = pose_stamp_q[pose_rd];
            i1 = image_stamp_q[image_rd];
            if (p1 < i1) begin
                if (pose_cnt > 1) begin
                    nxt = pose_stamp_q[qslot(pose_rd, 1)];
                    if (stamp_gap(nxt, i1) <= stamp_gap(p1, i1)) begin
                        pose_rd = qslot(pose_rd, 1);
                        pose_cnt--;
                        continue;
                    end
                end else if (!flushing) begin
                    break;
                end
            end else begin
                if (image_cnt > 1) begin
                    nxt = image_stamp_q[qslot(image_rd, 1)];
                    if (stamp_gap(nxt, p1) <= stamp_gap(i1, p1)) begin
                        image_rd = qslot(image_rd, 1);
                        image_cnt--;
                        continue;
                    end
                end else if (!flushing) begin
                    break;
                end
            end
            queue_result(KIND_MATCH, p1, i1, pose_tag_q[pose_rd], image_tag_q[image_rd], 1'b0);
            n++;
            pose_rd   = qslot(pose_rd, 1);
            pose_cnt--;
            image_rd  = qslot(image_rd, 1);
            image_cnt--;
        end
        return n;
    endfunction

    function automatic void predict_request(t_op op, logic [STAMP_BITS-1:0] st,
                                            logic [TAGW-1:0] tg);
        int n;
        n = 0;
        case (op)
            OP_PUSH_POSE: begin
                if (pose_cnt >= QDEPTH) begin
                    queue_result(KIND_DROP, st, '0, tg, '0, 1'b1);
                    return;
                end
                pose_stamp_q[qslot(pose_rd, pose_cnt)] = st;
                pose_tag_q[qslot(pose_rd, pose_cnt)]   = tg;
                pose_cnt++;
                n = match_heads(1'b0);
            end
            OP_PUSH_IMAGE: begin
                if (image_cnt >= QDEPTH) begin
                    queue_result(KIND_DROP, st, '0, tg, '0, 1'b1);
                    return;
                end
                image_stamp_q[qslot(image_rd, image_cnt)] = st;
                image_tag_q[qslot(image_rd, image_cnt)]   = tg;
                image_cnt++;
                n = match_heads(1'b0);
            end
            OP_FLUSH: begin
                n = match_heads(1'b1);
            end
            default: begin
            end
        endcase
        if (n > 0) begin
            exp_mem[EXP_AW'(exp_wr - 1)].last = 1'b1;
        end
    endfunction

    task automatic send_request(t_op op, logic [STAMP_BITS-1:0] st, logic [TAGW-1:0] tg);
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.stamp     <= st;
        req_ch.item_tag  <= tg;
        do @(posedge i_clk); while (!req_ch.ready);
        predict_request(op, st, tg);
    endtask

    task automatic test_idle_requests();
        send_request(OP_FLUSH, wide_random(), 16'hFFFF);
        send_request(OP_UNUSED, STAMP_MAX, 16'hFFFF);
    endtask

    task automatic test_field_extremes();
        send_request(OP_PUSH_POSE, '0, '0);
        send_request(OP_PUSH_IMAGE, '0, 16'hFFFF);
        send_request(OP_PUSH_POSE, STAMP_MAX, 16'hFFFF);
        send_request(OP_PUSH_IMAGE, STAMP_MAX, '0);
        send_request(OP_FLUSH, '0, '0);
    endtask

    task automatic test_distance_ties();
        send_request(OP_PUSH_POSE, 63'd100, 16'h0001);
        send_request(OP_PUSH_IMAGE, 63'd110, 16'h0002);
        send_request(OP_PUSH_POSE, 63'd120, 16'h0003);
        send_request(OP_PUSH_IMAGE, 63'd200, 16'h0004);
        send_request(OP_PUSH_IMAGE, 63'd1000, 16'h0005);
        send_request(OP_PUSH_POSE, 63'd1010, 16'h0006);
        send_request(OP_PUSH_IMAGE, 63'd1020, 16'h0007);
        send_request(OP_PUSH_POSE, 63'd1100, 16'h0008);
        send_request(OP_FLUSH, '0, '0);
    endtask

    task automatic test_pose_overflow();
        logic [STAMP_BITS-1:0] st;
        st = 63'd1000000;
        while (pose_cnt < QDEPTH) begin
            st = st + $urandom_range(1, 5000);
            send_request(OP_PUSH_POSE, st, tag_random());
        end
        send_request(OP_PUSH_POSE, wide_random(), tag_random());
        send_request(OP_PUSH_IMAGE, st - 63'd20000, tag_random());
        send_request(OP_FLUSH, '0, '0);
    endtask

    task automatic test_random_traffic(int count);
        int                    pick;
        int                    sent;
        t_op                   op;
        logic [STAMP_BITS-1:0] st;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                send_request(OP_UNUSED, wide_random(), tag_random());
                continue;
            end
            if (pick < 7) begin
                op = OP_FLUSH;
                st = wide_random();
            end else begin
                op = (pick < 42) ? OP_PUSH_POSE : OP_PUSH_IMAGE;
                sensor_clock = sensor_clock + $urandom_range(0, 2000);
                if (pick % 16 == 0)
                    st = wide_random();
                else if (pick % 9 == 0)
                    st = last_stamp;
                else
                    st = sensor_clock + $urandom_range(0, 300);
                last_stamp = st;
            end
            send_request(op, st, tag_random());
            sent++;
        end
    endtask

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            res_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            res_ch.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 2);
        end else begin
            res_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got_pair.kind        = res_ch.kind;
            got_pair.pose_stamp  = res_ch.pose_stamp;
            got_pair.image_stamp = res_ch.image_stamp;
            got_pair.pose_tag    = res_ch.pose_tag;
            got_pair.image_tag   = res_ch.image_tag;
            got_pair.last        = res_ch.last;
            if (exp_wr == exp_rd) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: %p", got_pair);
            end else begin
                want_pair = exp_mem[EXP_AW'(exp_rd)];
                exp_rd++;
                if (got_pair.kind !== want_pair.kind
                        || got_pair.pose_stamp !== want_pair.pose_stamp
                        || got_pair.image_stamp !== want_pair.image_stamp
                        || got_pair.pose_tag !== want_pair.pose_tag
                        || got_pair.image_tag !== want_pair.image_tag
                        || got_pair.last !== want_pair.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p, got %p", want_pair, got_pair);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_FLUSH;
        req_ch.stamp     = '0;
        req_ch.item_tag  = '0;
        res_ch.ready     = 1'b0;
        stall_left       = 0;
        cycles           = 0;
        mismatches       = 0;
        quiet_tail       = 1'b0;
        exp_wr           = 0;
        exp_rd           = 0;
        pose_rd          = '0;
        pose_cnt         = 0;
        image_rd         = '0;
        image_cnt        = 0;
        sensor_clock     = 63'd5000000;
        last_stamp       = 63'd5000000;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_requests();
        test_field_extremes();
        test_distance_ties();
        test_pose_overflow();
        test_random_traffic(90);
        quiet_tail = 1'b1;
        test_random_traffic(25);

        req_ch.valid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (mismatches == 0 && exp_wr == exp_rd)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule

/* sim.f */
hw/rtl/ntpm_pkg.sv
hw/rtl/ntpm_if.sv
hw/rtl/ntpm_ram.sv
hw/rtl/nearest_timestamp_pair_matcher.sv
test/tb.sv
